// ----- rtl/dht_pkg.sv -----
// Shared types and constants for the double-hashing hash table engine.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package dht_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int SIZE_W      = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int OP_W        = 2;
    localparam int CFG_W       = 7;
    localparam int CNT_W       = $clog2(KEY_W);

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [1:0] ST_FREE     = 2'd0;
    localparam logic [1:0] ST_OCCUPIED = 2'd1;
    localparam logic [1:0] ST_DELETED  = 2'd2;

    localparam logic [CFG_W-1:0] TABLE_SIZE_RESET = 7'd64;

    // Item as handed from the hashing front to the probing back.
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  h1;
        logic [IDX_W-1:0]  h2;
        logic [SIZE_W-1:0] m;
    } dht_item_t;

endpackage

// ----- rtl/dht_front.sv -----
// Front of the hash engine: accepts items and computes both hashes with a
// bit-serial remainder unit. Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [dht_pkg::OP_W-1:0]  opcode,
    input  logic signed [dht_pkg::KEY_W-1:0] key,
    input  logic [dht_pkg::CFG_W-1:0] table_size,
    output logic                      push_valid,
    input  logic                      push_ready,
    output dht_pkg::dht_item_t        push_item
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_DIV  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                  state_reg, state_next;
    logic [dht_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [dht_pkg::OP_W-1:0]    op_reg;
    logic [dht_pkg::KEY_W-1:0]   key_reg;
    logic [dht_pkg::KEY_W-1:0]   mag_reg, mag_next;
    logic                        neg_reg;
    logic [dht_pkg::SIZE_W-1:0]  m_reg;
    logic [dht_pkg::IDX_W-1:0]   r1_reg, r1_next;
    logic [dht_pkg::IDX_W-1:0]   r2_reg, r2_next;

    logic                        in_fire;
    logic [dht_pkg::SIZE_W-1:0]  m_clamp;
    logic [dht_pkg::SIZE_W-1:0]  d2;
    logic [dht_pkg::SIZE_W-1:0]  t1, t2;
    logic [dht_pkg::SIZE_W-1:0]  h1_full, h2_full;

    assign in_ready = (state_reg == F_IDLE);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        if (table_size < dht_pkg::CFG_W'(2))
            m_clamp = dht_pkg::SIZE_W'(2);
        else if (table_size > dht_pkg::CFG_W'(dht_pkg::TABLE_DEPTH))
            m_clamp = dht_pkg::SIZE_W'(dht_pkg::TABLE_DEPTH);
        else
            m_clamp = dht_pkg::SIZE_W'(table_size);
    end

    // One quotient bit per cycle for both divisors.
    assign d2 = m_reg - dht_pkg::SIZE_W'(1);
    assign t1 = {r1_reg, mag_reg[dht_pkg::KEY_W-1]};
    assign t2 = {r2_reg, mag_reg[dht_pkg::KEY_W-1]};

    always_comb
    begin
        r1_next = (t1 >= m_reg) ? dht_pkg::IDX_W'(t1 - m_reg) : dht_pkg::IDX_W'(t1);
        r2_next = (t2 >= d2)    ? dht_pkg::IDX_W'(t2 - d2)    : dht_pkg::IDX_W'(t2);
    end

    // Fold a negative key's remainder back into 0..d-1; the second hash adds one to it.
    always_comb
    begin
        if (neg_reg && (r1_reg != '0))
            h1_full = m_reg - {1'b0, r1_reg};
        else
            h1_full = {1'b0, r1_reg};
        if (neg_reg && (r2_reg != '0))
            h2_full = d2 - {1'b0, r2_reg} + dht_pkg::SIZE_W'(1);
        else
            h2_full = {1'b0, r2_reg} + dht_pkg::SIZE_W'(1);
    end

    assign push_valid     = (state_reg == F_PUSH);
    assign push_item.op   = op_reg;
    assign push_item.key  = key_reg;
    assign push_item.h1   = h1_full[dht_pkg::IDX_W-1:0];
    assign push_item.h2   = h2_full[dht_pkg::IDX_W-1:0];
    assign push_item.m    = m_reg;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        mag_next   = mag_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = F_DIV;
                    cnt_next   = '0;
                end
            end
            F_DIV:
            begin
                mag_next = {mag_reg[dht_pkg::KEY_W-2:0], 1'b0};
                cnt_next = cnt_reg + dht_pkg::CNT_W'(1);
                if (cnt_reg == dht_pkg::CNT_W'(dht_pkg::KEY_W - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg  <= opcode;
            key_reg <= key;
            neg_reg <= key[dht_pkg::KEY_W-1];
            mag_reg <= key[dht_pkg::KEY_W-1] ? (~key + dht_pkg::KEY_W'(1)) : key;
            m_reg   <= m_clamp;
            r1_reg  <= '0;
            r2_reg  <= '0;
        end
        else if (state_reg == F_DIV)
        begin
            mag_reg <= mag_next;
            r1_reg  <= r1_next;
            r2_reg  <= r2_next;
        end
    end

endmodule

// ----- rtl/dht_queue.sv -----
// Two-entry queue between the hashing front and the probing back.
// Depends on dht_pkg for the item type.
`timescale 1ns / 1ps

module dht_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  dht_pkg::dht_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output dht_pkg::dht_item_t pop_item
);

    dht_pkg::dht_item_t entry_reg [2];
    logic               wr_ptr_reg, rd_ptr_reg;
    logic [1:0]         count_reg, count_next;
    logic               push_fire, pop_fire;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push_fire && !pop_fire)
            count_next = count_reg + 2'd1;
        else if (pop_fire && !push_fire)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_fire)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop_fire)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_fire)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/dht_back.sv -----
// Back of the hash engine: walks the probe sequence over the slot store and
// holds the result register. Depends on dht_pkg.
`timescale 1ns / 1ps

module dht_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      pop_valid,
    output logic                      pop_ready,
    input  dht_pkg::dht_item_t        pop_item,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic [dht_pkg::IDX_W-1:0] slot_index
);

    localparam logic [1:0] B_IDLE  = 2'd0;
    localparam logic [1:0] B_PROBE = 2'd1;
    localparam logic [1:0] B_DONE  = 2'd2;
    localparam logic [1:0] B_CLEAR = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [dht_pkg::IDX_W-1:0]  clr_idx_reg;
    logic [dht_pkg::OP_W-1:0]   op_reg;
    logic [dht_pkg::KEY_W-1:0]  key_reg;
    logic [dht_pkg::IDX_W-1:0]  step_reg;
    logic [dht_pkg::SIZE_W-1:0] m_reg;
    logic [dht_pkg::IDX_W-1:0]  j_reg, j_next;
    logic [dht_pkg::SIZE_W-1:0] cnt_reg;

    logic                       chk_valid_reg;
    logic                       chk_last_reg;
    logic [dht_pkg::IDX_W-1:0]  chk_idx_reg;
    logic [dht_pkg::KEY_W-1:0]  chk_key_reg;
    logic [1:0]                 chk_state_reg;

    logic                       pend_status_reg, pend_status_next;
    logic [dht_pkg::IDX_W-1:0]  pend_slot_reg, pend_slot_next;

    logic                       out_valid_reg;
    logic                       status_reg;
    logic [dht_pkg::IDX_W-1:0]  slot_reg;

    logic [1:0]                 slot_state_mem [dht_pkg::TABLE_DEPTH];
    logic [dht_pkg::KEY_W-1:0]  slot_key_mem   [dht_pkg::TABLE_DEPTH];

    logic                       pop_fire;
    logic                       op_ok;
    logic                       issue_fire;
    logic                       finish;
    logic                       wr_key;
    logic                       wr_state;
    logic [1:0]                 wr_state_val;
    logic [1:0]                 chk_state;
    logic [dht_pkg::SIZE_W-1:0] j_sum;
    logic                       out_load;

    assign pop_ready = (state_reg == B_IDLE);
    assign pop_fire  = pop_valid && pop_ready;
    assign op_ok     = (pop_item.op == dht_pkg::OP_INSERT) ||
                       (pop_item.op == dht_pkg::OP_SEARCH) ||
                       (pop_item.op == dht_pkg::OP_DELETE);

    assign chk_state = chk_state_reg;

    // Next probe slot; j and the step both lie below m, so one subtract wraps it.
    assign j_sum  = {1'b0, j_reg} + {1'b0, step_reg};
    assign j_next = (j_sum >= m_reg) ? dht_pkg::IDX_W'(j_sum - m_reg)
                                     : dht_pkg::IDX_W'(j_sum);

    // Resolve the slot read issued in the previous cycle.
    always_comb
    begin
        finish           = 1'b0;
        wr_key           = 1'b0;
        wr_state         = 1'b0;
        wr_state_val     = dht_pkg::ST_OCCUPIED;
        pend_status_next = 1'b1;
        pend_slot_next   = '0;
        if (chk_valid_reg)
        begin
            if (op_reg == dht_pkg::OP_INSERT)
            begin
                if (chk_state != dht_pkg::ST_OCCUPIED)
                begin
                    finish           = 1'b1;
                    wr_key           = 1'b1;
                    wr_state         = 1'b1;
                    pend_status_next = 1'b0;
                    pend_slot_next   = chk_idx_reg;
                end
            end
            else if (chk_state == dht_pkg::ST_FREE)
            begin
                finish = 1'b1;
            end
            else if ((chk_state == dht_pkg::ST_OCCUPIED) && (chk_key_reg == key_reg))
            begin
                finish           = 1'b1;
                pend_status_next = 1'b0;
                pend_slot_next   = chk_idx_reg;
                if (op_reg == dht_pkg::OP_DELETE)
                begin
                    wr_state     = 1'b1;
                    wr_state_val = dht_pkg::ST_DELETED;
                end
            end
            if (chk_last_reg)
                finish = 1'b1;
        end
    end

    assign issue_fire = (state_reg == B_PROBE) && (cnt_reg < m_reg) && !finish;
    assign out_load   = (state_reg == B_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_idx_reg == dht_pkg::IDX_W'(dht_pkg::TABLE_DEPTH - 1))
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (pop_fire)
                    state_next = op_ok ? B_PROBE : B_DONE;
            end
            B_PROBE:
            begin
                if (finish)
                    state_next = B_DONE;
            end
            B_DONE:
            begin
                if (out_load)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_idx_reg   <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_valid_reg <= issue_fire;
            if (state_reg == B_CLEAR)
                clr_idx_reg <= clr_idx_reg + dht_pkg::IDX_W'(1);
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
        begin
            op_reg          <= pop_item.op;
            key_reg         <= pop_item.key;
            j_reg           <= pop_item.h1;
            step_reg        <= pop_item.h2;
            m_reg           <= pop_item.m;
            cnt_reg         <= '0;
            pend_status_reg <= 1'b1;
            pend_slot_reg   <= '0;
        end
        else
        begin
            if (issue_fire)
            begin
                j_reg        <= j_next;
                cnt_reg      <= cnt_reg + dht_pkg::SIZE_W'(1);
                chk_idx_reg  <= j_reg;
                chk_last_reg <= (cnt_reg == (m_reg - dht_pkg::SIZE_W'(1)));
            end
            if (finish)
            begin
                pend_status_reg <= pend_status_next;
                pend_slot_reg   <= pend_slot_next;
            end
        end
        if (out_load)
        begin
            status_reg <= pend_status_reg;
            slot_reg   <= pend_slot_reg;
        end
    end

    // Slot state store: clearing pass after reset, then one write and one
    // registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (state_reg == B_CLEAR)
            slot_state_mem[clr_idx_reg] <= dht_pkg::ST_FREE;
        else if (wr_state)
            slot_state_mem[chk_idx_reg] <= wr_state_val;
        chk_state_reg <= slot_state_mem[j_reg];
    end

    // Key store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_key)
            slot_key_mem[chk_idx_reg] <= key_reg;
        chk_key_reg <= slot_key_mem[j_reg];
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot_index = slot_reg;

    a_chk_follows_probe: assert property (@(posedge clk) disable iff (!rst_n)
        chk_valid_reg |-> $past(state_reg == B_PROBE))
        else $error("slot check without a probe issued");

    a_probe_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_PROBE) |-> ((cnt_reg <= m_reg) && ({1'b0, j_reg} < m_reg)))
        else $error("probe slot or count beyond table size");

    a_finish_writes_result: assert property (@(posedge clk) disable iff (!rst_n)
        (finish && (state_reg == B_PROBE)) |=> (state_reg == B_DONE))
        else $error("finished probe did not move to result");

    a_out_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> !$past(out_load))
        else $error("result overwritten while stalled");

endmodule

// ----- rtl/double_hash_table_engine.sv -----
// Top level of the double-hashing hash table engine: configuration port,
// hashing front, item queue and probing back. Depends on dht_pkg.
`timescale 1ns / 1ps

// Open-addressing table of 64 signed 32-bit keys, probed by double hashing
// over the table_size slots in use (clamped to 2..64). An item passes the
// bit-serial remainder unit that forms both hashes, then the probe walk in the
// back (one slot read per cycle from the key store), then the result register.
// Front and back overlap through a two-entry queue, so the front can hash a
// new item while the back probes; the front itself takes a new item only
// after handing the last one to the queue. After reset a clearing pass marks
// every slot free; items accepted meanwhile wait in the queue. Write
// table_size only while no item is in flight.

module double_hash_table_engine (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [dht_pkg::OP_W-1:0]  opcode,
    input  logic signed [dht_pkg::KEY_W-1:0] key,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      status,
    output logic [dht_pkg::IDX_W-1:0] slot_index
);

    localparam logic REG_TABLE_SIZE = 1'b0;

    logic [dht_pkg::CFG_W-1:0] table_size_reg;
    logic                      cfg_write;

    logic                      push_valid, push_ready;
    dht_pkg::dht_item_t        push_item;
    logic                      pop_valid, pop_ready;
    dht_pkg::dht_item_t        pop_item;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            table_size_reg <= dht_pkg::TABLE_SIZE_RESET;
        else if (cfg_write && (paddr[2] == REG_TABLE_SIZE))
            table_size_reg <= pwdata[dht_pkg::CFG_W-1:0];
    end

    assign prdata = (paddr[2] == REG_TABLE_SIZE)
                  ? {{(32 - dht_pkg::CFG_W){1'b0}}, table_size_reg}
                  : 32'd0;

    dht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .table_size (table_size_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item)
    );

    dht_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    dht_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index)
    );

endmodule

// ----- sim/double_hash_table_engine_test.sv -----
// Self-checking testbench for double_hash_table_engine: APB setup of the table
// size, valid/ready traffic on both channels, and a shadow table that predicts
// every result. Depends on dht_pkg and the engine RTL.
`timescale 1ns / 1ps

module double_hash_table_engine_test;

    localparam logic [dht_pkg::OP_W-1:0] OP_UNKNOWN = 2'd3;
    localparam logic [2:0]      ADDR_TABLE_SIZE = 3'd0;
    localparam logic [2:0]      ADDR_UNMAPPED   = 3'd4;
    localparam int QUIET_LIMIT     = 5000;
    localparam int DRAIN_CYCLES    = 100;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_ITEMS     = 200;
    localparam int POOL_SIZE       = 16;

    typedef struct packed {
        logic [dht_pkg::OP_W-1:0]  op;
        logic [dht_pkg::KEY_W-1:0] key;
    } table_req_t;

    typedef struct packed {
        logic                      status;
        logic [dht_pkg::IDX_W-1:0] slot;
    } table_resp_t;

    logic                       clk;
    logic                       rst_n      = 1'b0;
    logic                       psel       = 1'b0;
    logic                       penable    = 1'b0;
    logic                       pwrite     = 1'b0;
    logic [2:0]                 paddr      = '0;
    logic [31:0]                pwdata     = '0;
    logic [31:0]                prdata;
    logic                       pready;
    logic                       in_valid   = 1'b0;
    logic                       in_ready;
    logic [dht_pkg::OP_W-1:0]   opcode     = dht_pkg::OP_INSERT;
    logic [dht_pkg::KEY_W-1:0]  key        = '0;
    logic                       out_valid;
    logic                       out_ready  = 1'b0;
    logic                       status;
    logic [dht_pkg::IDX_W-1:0]  slot_index;

    // Shadow copy of the table and its size register
    logic [dht_pkg::KEY_W-1:0]  shadow_key   [dht_pkg::TABLE_DEPTH];
    logic [1:0]                 shadow_state [dht_pkg::TABLE_DEPTH];
    logic [dht_pkg::CFG_W-1:0]  shadow_size;

    table_req_t  pending_reqs[$];
    table_resp_t expected_resps[$];
    table_req_t  next_req;
    table_resp_t due_resp;

    int  issued;
    int  accepted;
    int  mismatches;
    int  hit_count;
    int  miss_count;
    int  sizes_used;
    int  op_count [4];
    int  tx_idle_pct;
    int  rx_stall_pct;
    int  rx_hold;
    bit  in_taken;

    double_hash_table_engine dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .slot_index (slot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---------------------------------------------------------------- predictor

    function automatic int modulus_of(logic [dht_pkg::CFG_W-1:0] size_reg);
        if (size_reg < 2)
            return 2;
        if (size_reg > dht_pkg::TABLE_DEPTH)
            return dht_pkg::TABLE_DEPTH;
        return int'(size_reg);
    endfunction

    // Remainder of the signed key, folded into 0..d-1
    function automatic int nonneg_rem(logic [dht_pkg::KEY_W-1:0] kbits, int d);
        longint kv;
        longint r;
        kv = longint'($signed(kbits));
        r  = kv % d;
        if (r < 0)
            r += d;
        return int'(r);
    endfunction

    function automatic int locate_key(logic [dht_pkg::KEY_W-1:0] kbits, int m);
        int j;
        int stride;
        j      = nonneg_rem(kbits, m);
        stride = 1 + nonneg_rem(kbits, m - 1);
        for (int i = 0; i < m; i++)
        begin
            if (shadow_state[j] == dht_pkg::ST_FREE)
                return -1;
            if (shadow_state[j] == dht_pkg::ST_OCCUPIED && shadow_key[j] == kbits)
                return j;
            j = (j + stride) % m;
        end
        return -1;
    endfunction

    function automatic table_resp_t apply_table_op(table_req_t req);
        int m;
        int j;
        int stride;
        int slot;
        table_resp_t resp;
        m    = modulus_of(shadow_size);
        slot = -1;
        case (req.op)
            dht_pkg::OP_INSERT:
            begin
                j      = nonneg_rem(req.key, m);
                stride = 1 + nonneg_rem(req.key, m - 1);
                // take the first slot not occupied; duplicates are not checked
                for (int i = 0; i < m && slot < 0; i++)
                begin
                    if (shadow_state[j] != dht_pkg::ST_OCCUPIED)
                    begin
                        shadow_key[j]   = req.key;
                        shadow_state[j] = dht_pkg::ST_OCCUPIED;
                        slot            = j;
                    end
                    else
                        j = (j + stride) % m;
                end
            end
            dht_pkg::OP_SEARCH:
                slot = locate_key(req.key, m);
            dht_pkg::OP_DELETE:
            begin
                slot = locate_key(req.key, m);
                if (slot >= 0)
                    shadow_state[slot] = dht_pkg::ST_DELETED;
            end
            default:
                slot = -1;
        endcase
        resp.status = (slot < 0);
        resp.slot   = (slot < 0) ? '0 : dht_pkg::IDX_W'(slot);
        return resp;
    endfunction

    task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
    endtask

    // ---------------------------------------------------------------- driver

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_taken)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                next_req = pending_reqs.pop_front();
                in_valid <= 1'b1;
                opcode   <= next_req.op;
                key      <= next_req.key;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Hold off the result channel for a counted stretch, else stall at random
    always @(negedge clk)
    begin
        if (rx_hold > 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin
        in_taken = 1'b0;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_resps.size() == 0)
                    note_mismatch("result with nothing pending", '0, {status, slot_index});
                else
                begin
                    due_resp = expected_resps.pop_front();
                    if (status !== due_resp.status)
                        note_mismatch("status", due_resp.status, status);
                    if (slot_index !== due_resp.slot)
                        note_mismatch("slot_index", due_resp.slot, slot_index);
                end
                if (status)
                    miss_count++;
                else
                    hit_count++;
            end
            if (in_valid && in_ready)
            begin
                expected_resps.push_back(apply_table_op({opcode, key}));
                op_count[opcode]++;
                accepted++;
                in_taken = 1'b1;
            end
        end
    end

    // Stop the run if no transfer happens on either channel for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // ---------------------------------------------------------------- sequencing

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_table_size_reg();
        logic [31:0] got;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_TABLE_SIZE;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== {25'd0, shadow_size})
            note_mismatch("table_size readback", shadow_size, got);
    endtask

    task automatic set_table_size(logic [dht_pkg::CFG_W-1:0] size_val);
        apb_write(ADDR_TABLE_SIZE, {25'd0, size_val});
        shadow_size = size_val;
        sizes_used++;
        check_table_size_reg();
    endtask

    task automatic queue_req(logic [dht_pkg::OP_W-1:0] op, logic [dht_pkg::KEY_W-1:0] k);
        pending_reqs.push_back('{op: op, key: k});
        issued++;
    endtask

    task automatic drain();
        while (accepted < issued || expected_resps.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(logic [dht_pkg::CFG_W-1:0] size_val, int tx_pct,
                                    int rx_pct, bit hold_rx);
        logic [dht_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
        logic [dht_pkg::OP_W-1:0]  op;
        logic [dht_pkg::KEY_W-1:0] k;
        int m;
        int pick;
        set_table_size(size_val);
        m = modulus_of(size_val);
        // half the pool shares a first hash so probe chains get long
        for (int i = 0; i < POOL_SIZE; i++)
            key_pool[i] = (i == 0 || i >= POOL_SIZE / 2)
                        ? dht_pkg::KEY_W'($urandom)
                        : key_pool[0] + dht_pkg::KEY_W'(i * m);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (hold_rx)
        begin
            @(posedge clk);
            rx_hold = HOLD_OFF_CYCLES;
        end
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 38)
                op = dht_pkg::OP_INSERT;
            else if (pick < 70)
                op = dht_pkg::OP_SEARCH;
            else if (pick < 95)
                op = dht_pkg::OP_DELETE;
            else
                op = OP_UNKNOWN;
            pick = $urandom_range(9);
            if (pick < 6)
                k = key_pool[$urandom_range(POOL_SIZE - 1)];
            else if (pick < 8)
                k = dht_pkg::KEY_W'($urandom);
            else
                k = dht_pkg::KEY_W'($urandom_range(400) - 200);
            queue_req(op, k);
        end
        drain();
    endtask

    initial
    begin
        logic [dht_pkg::CFG_W-1:0] size_plan [10];
        for (int i = 0; i < dht_pkg::TABLE_DEPTH; i++)
        begin
            shadow_key[i]   = '0;
            shadow_state[i] = dht_pkg::ST_FREE;
        end
        shadow_size  = dht_pkg::TABLE_SIZE_RESET;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset value, then a write to an unmapped register must change nothing
        check_table_size_reg();
        apb_write(ADDR_UNMAPPED, 32'd5);
        check_table_size_reg();

        // directed: empty table, key extremes, full table, duplicates, deletes
        set_table_size(7'd4);
        queue_req(dht_pkg::OP_SEARCH, 32'h0000_0000);
        queue_req(dht_pkg::OP_INSERT, 32'h8000_0000);
        queue_req(dht_pkg::OP_INSERT, 32'h7FFF_FFFF);
        queue_req(dht_pkg::OP_INSERT, 32'hFFFF_FFFF);
        queue_req(dht_pkg::OP_INSERT, 32'h0000_0000);
        queue_req(dht_pkg::OP_INSERT, 32'h0000_0005);
        queue_req(dht_pkg::OP_INSERT, 32'h8000_0000);
        queue_req(dht_pkg::OP_SEARCH, 32'h8000_0000);
        queue_req(dht_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        queue_req(dht_pkg::OP_DELETE, 32'h7FFF_FFFF);
        queue_req(dht_pkg::OP_SEARCH, 32'h7FFF_FFFF);
        queue_req(dht_pkg::OP_INSERT, 32'h8000_0000);
        queue_req(dht_pkg::OP_SEARCH, 32'h8000_0000);
        queue_req(dht_pkg::OP_DELETE, 32'h8000_0000);
        queue_req(dht_pkg::OP_SEARCH, 32'h8000_0000);
        queue_req(dht_pkg::OP_DELETE, 32'h1234_5678);
        queue_req(dht_pkg::OP_SEARCH, 32'h1234_5678);
        queue_req(OP_UNKNOWN, 32'hA5A5_A5A5);
        queue_req(OP_UNKNOWN, 32'h5A5A_5A5A);
        queue_req(dht_pkg::OP_DELETE, 32'hFFFF_FFFF);
        queue_req(dht_pkg::OP_INSERT, 32'hFFFF_FFFE);
        queue_req(dht_pkg::OP_SEARCH, 32'h0000_0000);
        drain();

        // sizes below 2 and above the depth are clamped by the engine
        size_plan = '{7'd64, 7'd2, 7'd0, 7'd1, 7'd127, 7'd3, 7'd65, 7'd16,
                      dht_pkg::CFG_W'($urandom_range(64, 2)), 7'd64};
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph % 4)
                0: run_random_phase(size_plan[ph], 0, 0, ph == 0);
                1: run_random_phase(size_plan[ph], 49, 0, 1'b0);
                2: run_random_phase(size_plan[ph], 0, 49, 1'b0);
                default: run_random_phase(size_plan[ph], 19, 19, 1'b0);
            endcase
        end

        // let any stray result show up before the verdict
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d transfers (insert %0d, search %0d, delete %0d, unknown %0d)",
                 accepted, op_count[dht_pkg::OP_INSERT], op_count[dht_pkg::OP_SEARCH],
                 op_count[dht_pkg::OP_DELETE], op_count[OP_UNKNOWN]);
        $display("over %0d table size settings: %0d hits, %0d misses or full, %0d mismatches",
                 sizes_used, hit_count, miss_count, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
